[hw/rtl/nsf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package nsf_pkg;

  localparam int BUFFER_DEPTH_DEF = 128;

  localparam logic [1:0] OP_RX      = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  localparam logic [1:0] TERM_COUNT = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] rx_byte;
    logic [6:0] read_index;
  } in_t;

  typedef struct packed {
    logic       ready_res;
    logic       frame_done;
    logic [7:0] frame_length;
    logic       byte_stored;
    logic [7:0] read_data;
  } out_t;

  typedef struct packed {
    logic       ready_res;
    logic       frame_done;
    logic [7:0] frame_length;
    logic       byte_stored;
  } step_res_t;

endpackage

`default_nettype wire

[hw/rtl/nsf_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module nsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[hw/rtl/nsf_frame_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module nsf_frame_ctrl #(
  parameter int BUFFER_DEPTH = nsf_pkg::BUFFER_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            step,
  input  wire nsf_pkg::in_t                    item,
  output logic                                 wr_en,
  output logic      [$clog2(BUFFER_DEPTH)-1:0] wr_addr,
  output logic      [7:0]                      wr_data,
  output nsf_pkg::step_res_t                   res
);

  localparam int WPW = $clog2(BUFFER_DEPTH + 1);
  localparam int AW  = $clog2(BUFFER_DEPTH);

  logic [WPW-1:0] wpos_r, wpos_nxt;
  logic [1:0]     ret_r, ret_nxt;
  logic [1:0]     nl_r, nl_nxt;
  logic           cap_r, cap_nxt;
  logic           rdy_r, rdy_nxt;
  logic           cap_eff;
  logic           room;
  logic           store;
  logic           done;

  always_comb begin
    wpos_nxt = wpos_r;
    ret_nxt  = ret_r;
    nl_nxt   = nl_r;
    cap_nxt  = cap_r;
    rdy_nxt  = rdy_r;
    cap_eff  = cap_r || (item.rx_byte == nsf_pkg::CH_DOLLAR);
    room     = wpos_r < WPW'(BUFFER_DEPTH);
    store    = 1'b0;
    done     = 1'b0;
    if (step) begin
      case (item.op)
        nsf_pkg::OP_RX: begin
          if (!rdy_r) begin
            cap_nxt = cap_eff;
            if (cap_eff) begin
              if (item.rx_byte == nsf_pkg::CH_CR) begin
                ret_nxt = (ret_r < nsf_pkg::TERM_COUNT) ? ret_r + 2'd1 : nsf_pkg::TERM_COUNT;
                store   = room;
              end else if (item.rx_byte == nsf_pkg::CH_LF) begin
                nl_nxt = (nl_r < nsf_pkg::TERM_COUNT) ? nl_r + 2'd1 : nsf_pkg::TERM_COUNT;
                store  = room;
              end else if (((ret_r < nsf_pkg::TERM_COUNT) || (nl_r < nsf_pkg::TERM_COUNT))
                           && room) begin
                store = 1'b1;
              end else begin
                done     = 1'b1;
                rdy_nxt  = 1'b1;
                wpos_nxt = '0;
                ret_nxt  = '0;
                nl_nxt   = '0;
                cap_nxt  = 1'b0;
              end
            end
          end
        end
        nsf_pkg::OP_RELEASE: begin
          rdy_nxt = 1'b0;
        end
        default: begin
        end
      endcase
      if (store) begin
        wpos_nxt = wpos_r + WPW'(1);
      end
    end
  end

  assign wr_en   = store;
  assign wr_addr = wpos_r[AW-1:0];
  assign wr_data = item.rx_byte;

  assign res.ready_res    = rdy_nxt;
  assign res.frame_done   = done;
  assign res.frame_length = done ? 8'(wpos_r) : 8'd0;
  assign res.byte_stored  = store;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wpos_r <= '0;
      ret_r  <= '0;
      nl_r   <= '0;
      cap_r  <= 1'b0;
      rdy_r  <= 1'b0;
    end else begin
      wpos_r <= wpos_nxt;
      ret_r  <= ret_nxt;
      nl_r   <= nl_nxt;
      cap_r  <= cap_nxt;
      rdy_r  <= rdy_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_wpos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wpos_r <= WPW'(BUFFER_DEPTH))
    else $error("write position beyond buffer depth");

  a_ready_no_capture: assert property (@(posedge clk) disable iff (!rst_n)
    rdy_r |-> !cap_r)
    else $error("capture active while a frame waits");

  a_done_sets_ready: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> (rdy_r && (wpos_r == '0) && (ret_r == '0) && (nl_r == '0)))
    else $error("frame close did not set ready and clear counters");

  a_store_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (cap_eff && !rdy_r && room))
    else $error("buffer write without capture or room");
`endif

endmodule

`default_nettype wire

[hw/rtl/nmea_sentence_framer.sv]
// Frames the serial byte stream of a GPS receiver into a sentence buffer.
// Input channel (in_valid/in_ready/in_data) carries one operation per
// transaction: a received byte, a release of the ready flag, or a read of
// one buffer entry. Every input transaction yields exactly one result
// transaction on the output channel (out_valid/out_ready/out_data).
// A '$' starts capture; bytes are stored until two carriage returns and two
// line feeds have been seen or the buffer is full; the next byte other than CR
// or LF closes the frame, reporting its length and raising the ready flag.
// An accepted transaction is held in an input register and its result is
// then written to the output register once that register is free. One
// transaction is accepted per cycle while the receiver does not stall; the
// rate is set by the single pass through the framing logic and the one write
// or read on the buffer memory in that pass.
// When the receiver stalls, the result stays in the output register while the
// input register still takes one more transaction; after that in_ready drops.
// Synchronous reset clears the counters, the flags and both valid bits; the
// buffer contents are not cleared and an entry reads back only once written.
`timescale 1ns / 1ps
`default_nettype none

module nmea_sentence_framer #(
  parameter int BUFFER_DEPTH = nsf_pkg::BUFFER_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire nsf_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output nsf_pkg::out_t      out_data
);

  localparam int AW = $clog2(BUFFER_DEPTH);

  logic                s1_valid_r;
  nsf_pkg::in_t        s1_item_r;
  logic                adv;
  logic                out_valid_r;
  nsf_pkg::step_res_t  res;
  nsf_pkg::step_res_t  res_r;
  logic                rd_sel_r;
  logic                rd_en;
  logic [8:0]          idx_ext;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [7:0]          wr_data;
  logic [7:0]          rd_q;

  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;
  assign idx_ext  = {2'b00, s1_item_r.read_index};
  assign rd_en    = adv && (s1_item_r.op == nsf_pkg::OP_READ)
                    && (idx_ext < 9'(BUFFER_DEPTH));

  nsf_frame_ctrl #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (adv),
    .item    (s1_item_r),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .res     (res)
  );

  nsf_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (idx_ext[AW-1:0]),
    .rdata (rd_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
    if (adv) begin
      res_r    <= res;
      rd_sel_r <= rd_en;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_data.ready_res    = res_r.ready_res;
  assign out_data.frame_done   = res_r.frame_done;
  assign out_data.frame_length = res_r.frame_length;
  assign out_data.byte_stored  = res_r.byte_stored;
  assign out_data.read_data    = rd_sel_r ? rd_q : 8'd0;

endmodule

`default_nettype wire
